/* rtl/rtwm_pkg.sv */
package rtwm_pkg;

   // Field widths fixed by the interface.
   localparam int SYMBOL_W        = 2;
   localparam int POSITION_W      = 32;
   localparam int SPAN_W          = 4;
   localparam int LENGTH_W        = 5;
   localparam int PATTERN_W       = 32;
   localparam int PATTERN_SYMBOLS = PATTERN_W / SYMBOL_W;
   localparam int KIND_W          = 2;
   localparam int CSR_INDEX_W     = 1;

   // Default window depth.
   localparam int MAX_PATTERN_DEFAULT = 16;

   // Register reset values.
   localparam logic [PATTERN_W-1:0] PATTERN_RESET = '0;
   localparam logic [LENGTH_W-1:0]  LENGTH_RESET  = 5'd9;

   // Match result codes.
   typedef logic [KIND_W-1:0] match_kind_type;
   localparam match_kind_type MATCH_NONE     = 2'd0;
   localparam match_kind_type MATCH_EXACT    = 2'd1;
   localparam match_kind_type MATCH_REVERSAL = 2'd2;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_SYMBOLS = 1'b0,
      CSR_PATTERN_LENGTH  = 1'b1
   } csr_index_type;

   // Request payload.
   typedef struct packed {
      logic [SYMBOL_W-1:0] symbol;
      logic                new_text;
   } req_payload_type;

   // Response payload.
   typedef struct packed {
      match_kind_type        match_kind;
      logic [POSITION_W-1:0] window_start;
      logic [SPAN_W-1:0]     span_first;
      logic [SPAN_W-1:0]     span_last;
   } rsp_payload_type;

endpackage

/* rtl/rtwm_compare.sv */
module rtwm_compare
   import rtwm_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_stall,
   input  logic [MAX_PATTERN-1:0][SYMBOL_W-1:0]   window,
   input  logic [MAX_PATTERN-1:0][SYMBOL_W-1:0]   pattern,
   input  logic [$clog2(MAX_PATTERN+1)-1:0]       length,
   input  logic [POSITION_W-1:0]                  start,
   output logic                                   out_valid,
   input  logic                                   out_stall,
   output logic [MAX_PATTERN-1:0][SYMBOL_W-1:0]   aligned_out,
   output logic [$clog2(MAX_PATTERN)-1:0]         first_out,
   output logic [$clog2(MAX_PATTERN)-1:0]         last_out,
   output logic                                   any_out,
   output logic [POSITION_W-1:0]                  start_out
);

   localparam int IW = $clog2(MAX_PATTERN);
   localparam int NW = $clog2(MAX_PATTERN + 1);

   logic [MAX_PATTERN-1:0][SYMBOL_W-1:0] aligned;
   logic [MAX_PATTERN-1:0]               mismatch;
   logic [IW-1:0]                        first;
   logic [IW-1:0]                        last;

   logic                                 valid_ff, valid_in;
   logic [MAX_PATTERN-1:0][SYMBOL_W-1:0] aligned_ff;
   logic [IW-1:0]                        first_ff;
   logic [IW-1:0]                        last_ff;
   logic                                 any_ff;
   logic [POSITION_W-1:0]                start_ff;
   logic                                 load;

   // Reorder the window so that index 0 is the oldest symbol, then compare.
   always_comb begin
      logic [NW-1:0] k;
      k        = '0;
      aligned  = '0;
      mismatch = '0;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if (NW'(i) < length) begin
            k           = length - NW'(1) - NW'(i);
            aligned[i]  = window[k[IW-1:0]];
            mismatch[i] = aligned[i] != pattern[i];
         end
      end
   end

   // Locate the first and the last mismatch.
   always_comb begin
      first = '0;
      last  = '0;
      for (int i = MAX_PATTERN - 1; i >= 0; i--) begin
         if (mismatch[i]) first = IW'(i);
      end
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if (mismatch[i]) last = IW'(i);
      end
   end

   assign in_stall = valid_ff && out_stall;
   assign load     = in_valid && !in_stall;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else begin
         valid_in = valid_ff && out_stall;
      end
   end

   // Stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         aligned_ff <= aligned;
         first_ff   <= first;
         last_ff    <= last;
         any_ff     <= |mismatch;
         start_ff   <= start;
      end
   end

   assign out_valid   = valid_ff;
   assign aligned_out = aligned_ff;
   assign first_out   = first_ff;
   assign last_out    = last_ff;
   assign any_out     = any_ff;
   assign start_out   = start_ff;

   // The mismatch span is never inverted.
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && any_ff |-> first_ff <= last_ff)
      else $error("mismatch span inverted");

   // A clean compare leaves both span ends at zero.
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && !any_ff |-> first_ff == '0 && last_ff == '0)
      else $error("span set without mismatch");

endmodule

/* rtl/rtwm_reverse.sv */
module rtwm_reverse
   import rtwm_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_stall,
   input  logic [MAX_PATTERN-1:0][SYMBOL_W-1:0] aligned,
   input  logic [MAX_PATTERN-1:0][SYMBOL_W-1:0] pattern,
   input  logic [$clog2(MAX_PATTERN)-1:0]       first,
   input  logic [$clog2(MAX_PATTERN)-1:0]       last,
   input  logic                                 any,
   input  logic [POSITION_W-1:0]                start,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output rsp_payload_type                      rsp_payload
);

   localparam int IW = $clog2(MAX_PATTERN);
   localparam int SW = IW + 1;

   logic            ok;
   match_kind_type  kind;
   logic            valid_ff, valid_in;
   rsp_payload_type payload_ff;
   logic            load;

   // The window span read backwards must equal the pattern span.
   always_comb begin
      logic [SW-1:0] sum;
      logic [SW-1:0] m;
      sum = {1'b0, first} + {1'b0, last};
      m   = '0;
      ok  = 1'b1;
      for (int j = 0; j < MAX_PATTERN; j++) begin
         if (IW'(j) >= first && IW'(j) <= last) begin
            m = sum - SW'(j);
            if (aligned[m[IW-1:0]] != pattern[j]) ok = 1'b0;
         end
      end
   end

   // Classify the window.
   always_comb begin
      priority if (!any) begin
         kind = MATCH_EXACT;
      end else if (first < last && ok) begin
         kind = MATCH_REVERSAL;
      end else begin
         kind = MATCH_NONE;
      end
   end

   assign in_stall = valid_ff && rsp_stall;
   assign load     = in_valid && !in_stall;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else begin
         valid_in = valid_ff && rsp_stall;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         payload_ff.match_kind   <= kind;
         payload_ff.window_start <= start;
         payload_ff.span_first   <= SPAN_W'(first);
         payload_ff.span_last    <= SPAN_W'(last);
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = payload_ff;

   // Only the three defined result codes leave the block.
   assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> payload_ff.match_kind != 2'd3)
      else $error("undefined match code");

   // A window without mismatches is reported as exact.
   assert property (@(posedge clock) disable iff (reset)
      load && !any |=> payload_ff.match_kind == MATCH_EXACT)
      else $error("exact window not reported as exact");

endmodule

/* rtl/reversal_tolerant_window_match_top.sv */
// An accepted request is held in the window register, then in the compare stage register,
// then in the reversal check and response register, which presents the response.
// Throughput: one request per cycle; a stalled response holds the pipeline.
// A request that leaves the window short of the pattern length gives no response.
// Reset (synchronous, active high) empties the pipeline, clears fill count, text
// position and window, and sets the pattern to all A with length nine.
module reversal_tolerant_window_match_top
   import rtwm_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  csr_index_type         csr_index,
   input  logic [PATTERN_W-1:0]  csr_data
);

   localparam int IW = $clog2(MAX_PATTERN);
   localparam int NW = $clog2(MAX_PATTERN + 1);

   logic [PATTERN_W-1:0]                 pattern_symbols_ff;
   logic [LENGTH_W-1:0]                  pattern_length_ff;
   logic [MAX_PATTERN-1:0][SYMBOL_W-1:0] window_ff, window_in;
   logic [NW-1:0]                        fill_ff, fill_in, fill_base;
   logic [POSITION_W-1:0]                position_ff, position_in, position_base;
   logic                                 s1_valid_ff, s1_valid_in;
   logic                                 s1_stall;
   logic [NW-1:0]                        length;
   logic [MAX_PATTERN-1:0][SYMBOL_W-1:0] pattern;
   logic                                 accept;
   logic                                 full;

   logic                                 s2_valid, s2_stall;
   logic [MAX_PATTERN-1:0][SYMBOL_W-1:0] s2_aligned;
   logic [IW-1:0]                        s2_first, s2_last;
   logic                                 s2_any;
   logic [POSITION_W-1:0]                s2_start;

   // Configuration registers; writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_symbols_ff <= PATTERN_RESET;
         pattern_length_ff  <= LENGTH_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PATTERN_SYMBOLS: pattern_symbols_ff <= csr_data;
            CSR_PATTERN_LENGTH:  pattern_length_ff  <= csr_data[LENGTH_W-1:0];
         endcase
      end
   end

   // Pattern symbols past the register width read as A.
   for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_pattern
      if (i < PATTERN_SYMBOLS) begin : g_reg
         assign pattern[i] = pattern_symbols_ff[SYMBOL_W*i +: SYMBOL_W];
      end else begin : g_zero
         assign pattern[i] = '0;
      end
   end

   // Effective length, clamped to one through the window depth.
   always_comb begin
      priority if (pattern_length_ff == '0) begin
         length = NW'(1);
      end else if (32'(pattern_length_ff) > 32'(MAX_PATTERN)) begin
         length = NW'(MAX_PATTERN);
      end else begin
         length = NW'(pattern_length_ff);
      end
   end

   assign req_stall = s1_valid_ff && s1_stall;
   assign accept    = req_valid && !req_stall;

   // Window shift, fill count and text position for the next request.
   always_comb begin
      fill_base     = req_payload.new_text ? '0 : fill_ff;
      position_base = req_payload.new_text ? '0 : position_ff;
      if (fill_base < NW'(MAX_PATTERN)) begin
         fill_in = fill_base + NW'(1);
      end else begin
         fill_in = fill_base;
      end
      position_in = position_base + POSITION_W'(1);
      window_in   = {window_ff[MAX_PATTERN-2:0], req_payload.symbol};
      full        = fill_in >= length;
      if (accept) begin
         s1_valid_in = full;
      end else begin
         s1_valid_in = s1_valid_ff && s1_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff   <= '0;
         fill_ff     <= '0;
         position_ff <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (accept) begin
            window_ff   <= window_in;
            fill_ff     <= fill_in;
            position_ff <= position_in;
         end
      end
   end

   // Align and compare.
   rtwm_compare #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_compare (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s1_valid_ff),
      .in_stall    (s1_stall),
      .window      (window_ff),
      .pattern     (pattern),
      .length      (length),
      .start       (position_ff - POSITION_W'(length)),
      .out_valid   (s2_valid),
      .out_stall   (s2_stall),
      .aligned_out (s2_aligned),
      .first_out   (s2_first),
      .last_out    (s2_last),
      .any_out     (s2_any),
      .start_out   (s2_start)
   );

   // Reversal check and response register.
   rtwm_reverse #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_reverse (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s2_valid),
      .in_stall    (s2_stall),
      .aligned     (s2_aligned),
      .pattern     (pattern),
      .first       (s2_first),
      .last        (s2_last),
      .any         (s2_any),
      .start       (s2_start),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // A request that leaves the window short produces nothing downstream.
   assert property (@(posedge clock) disable iff (reset)
      accept && !full |=> !s1_valid_ff)
      else $error("short window entered the pipeline");

endmodule
